@@ design/etcm_pkg.sv @@
// ----------------------------------------------------------------------------
// etcm_pkg
// Shared types, codes and helper functions of the exon coordinate mapper.
// ----------------------------------------------------------------------------
package etcm_pkg;

  localparam int POS_W  = 32;
  localparam int CHAR_W = 8;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_CHAR  = 2'd1,
    OP_QUERY = 2'd2,
    OP_CLEAR = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    ST_DONE  = 3'd0,
    ST_BASE  = 3'd1,
    ST_GAP   = 3'd2,
    ST_DROP  = 3'd3,
    ST_QUERY = 3'd4,
    ST_FULL  = 3'd5
  } rsp_status_e;

  typedef enum logic [2:0] {
    BASE_A    = 3'd0,
    BASE_C    = 3'd1,
    BASE_G    = 3'd2,
    BASE_U    = 3'd3,
    BASE_MASK = 3'd4
  } base_e;

  localparam logic [CHAR_W-1:0] CHAR_A_UP = "A";
  localparam logic [CHAR_W-1:0] CHAR_A_LO = "a";
  localparam logic [CHAR_W-1:0] CHAR_C_UP = "C";
  localparam logic [CHAR_W-1:0] CHAR_C_LO = "c";
  localparam logic [CHAR_W-1:0] CHAR_G_UP = "G";
  localparam logic [CHAR_W-1:0] CHAR_G_LO = "g";
  localparam logic [CHAR_W-1:0] CHAR_T_UP = "T";
  localparam logic [CHAR_W-1:0] CHAR_T_LO = "t";
  localparam logic [CHAR_W-1:0] CHAR_U_UP = "U";
  localparam logic [CHAR_W-1:0] CHAR_U_LO = "u";
  localparam logic [CHAR_W-1:0] CHAR_X_UP = "X";
  localparam logic [CHAR_W-1:0] CHAR_X_LO = "x";
  localparam logic [CHAR_W-1:0] CHAR_DASH = "-";

  // Datapath actions, one per cycle
  typedef enum logic [4:0] {
    DP_NOP,
    DP_CAPTURE,
    DP_LD_FIX,
    DP_LD_LEN,
    DP_LD_UPD,
    DP_CLEAR,
    DP_Q_INIT,
    DP_Q_CHK,
    DP_Q_ADD,
    DP_Q_FIN,
    DP_RES,
    DP_EMIT,
    DP_SCAN_HEAD,
    DP_SCAN_NEXT,
    DP_SCAN_STEP,
    DP_SCAN_FOUND,
    DP_EXHAUST,
    DP_EXH_DROP
  } dp_act_e;

  typedef struct packed {
    dp_act_e     act;
    rsp_status_e code;   // status for DP_RES
  } etcm_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic surplus;
    logic is_dash;
    logic started;
    logic at_end;
    logic next_none;
    logic rd_nonempty;
    logic scan_bound;
    logic idx_last;
    logic q_break;
  } etcm_sts_t;

  typedef struct packed {
    base_e base;
    logic  illegal;
  } base_dec_t;

  // Actions that load the result register
  function automatic logic is_result_act(dp_act_e act);
    logic r;
    case (act)
      DP_LD_UPD, DP_CLEAR, DP_Q_FIN, DP_RES, DP_EMIT, DP_EXH_DROP: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic [POS_W-1:0] exon_len(logic [POS_W-1:0] s, logic [POS_W-1:0] e);
    logic [POS_W-1:0] r;
    r = (e >= s) ? (e - s + POS_W'(1)) : '0;
    return r;
  endfunction

  function automatic base_dec_t decode_char(logic [CHAR_W-1:0] c);
    base_dec_t r;
    r.illegal = 1'b0;
    case (c)
      CHAR_A_UP, CHAR_A_LO: r.base = BASE_A;
      CHAR_C_UP, CHAR_C_LO: r.base = BASE_C;
      CHAR_G_UP, CHAR_G_LO: r.base = BASE_G;
      CHAR_T_UP, CHAR_T_LO, CHAR_U_UP, CHAR_U_LO: r.base = BASE_U;
      CHAR_X_UP, CHAR_X_LO: r.base = BASE_MASK;
      default: begin
        r.base    = BASE_MASK;
        r.illegal = 1'b1;
      end
    endcase
    return r;
  endfunction

endpackage

@@ design/etcm_req_if.sv @@
// ----------------------------------------------------------------------------
// etcm_req_if
// Request channel: valid/ready handshake carrying one command word.
// ----------------------------------------------------------------------------
interface etcm_req_if import etcm_pkg::*; ();

  logic              valid;
  logic              ready;
  logic [1:0]        opcode;
  logic [POS_W-1:0]  exon_first;
  logic [POS_W-1:0]  exon_last;
  logic [CHAR_W-1:0] char_in;
  logic [POS_W-1:0]  query_position;

  modport source (
    output valid, opcode, exon_first, exon_last, char_in, query_position,
    input  ready
  );

  modport sink (
    input  valid, opcode, exon_first, exon_last, char_in, query_position,
    output ready
  );

endinterface

@@ design/etcm_rsp_if.sv @@
// ----------------------------------------------------------------------------
// etcm_rsp_if
// Response channel: valid/ready handshake carrying one result word.
// ----------------------------------------------------------------------------
interface etcm_rsp_if import etcm_pkg::*; ();

  logic             valid;
  logic             ready;
  logic [2:0]       status;
  logic [2:0]       base_code;
  logic             illegal_char;
  logic [POS_W-1:0] seq_position;
  logic [POS_W-1:0] chrom_position;

  modport source (
    output valid, status, base_code, illegal_char, seq_position, chrom_position,
    input  ready
  );

  modport sink (
    input  valid, status, base_code, illegal_char, seq_position, chrom_position,
    output ready
  );

endinterface

@@ design/etcm_datapath.sv @@
// ----------------------------------------------------------------------------
// etcm_datapath
// Exon tables, length and cursor registers, query accumulator and the
// result register. Executes one action per cycle from the controller.
// ----------------------------------------------------------------------------
module etcm_datapath import etcm_pkg::*; #(
  parameter int MAX_EXONS = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  etcm_cmd_t         cmd_i,
  output etcm_sts_t         sts_o,
  input  logic [POS_W-1:0]  exon_first_i,
  input  logic [POS_W-1:0]  exon_last_i,
  input  logic [CHAR_W-1:0] char_in_i,
  input  logic [POS_W-1:0]  query_position_i,
  input  logic              strand_minus_we_i,
  input  logic              strand_minus_i,
  output logic [2:0]        status_o,
  output logic [2:0]        base_code_o,
  output logic              illegal_char_o,
  output logic [POS_W-1:0]  seq_position_o,
  output logic [POS_W-1:0]  chrom_position_o
);

  localparam int CW = $clog2(MAX_EXONS + 1);
  localparam int AW = (MAX_EXONS > 1) ? $clog2(MAX_EXONS) : 1;

  // exon tables
  logic [POS_W-1:0] start_mem [MAX_EXONS];
  logic [POS_W-1:0] end_mem   [MAX_EXONS];

  // control registers
  logic [CW-1:0]    count_q, count_d;
  logic [POS_W-1:0] total_q, total_d;
  logic [POS_W-1:0] emitted_q, emitted_d;
  logic [AW-1:0]    cursor_exon_q, cursor_exon_d;
  logic [POS_W-1:0] cursor_pos_q, cursor_pos_d;
  logic             started_q, started_d;
  logic             strand_q, strand_d;

  // payload registers
  logic [POS_W-1:0]  first_q, first_d;
  logic [POS_W-1:0]  last_q, last_d;
  logic [CHAR_W-1:0] ch_q, ch_d;
  logic [POS_W-1:0]  qpos_q, qpos_d;
  logic [POS_W-1:0]  fix_last_q, fix_last_d;
  logic              merge_q, merge_d;
  logic [POS_W-1:0]  new_len_q, new_len_d;
  logic [POS_W-1:0]  old_len_q, old_len_d;
  logic [POS_W-1:0]  last_start_q, last_start_d;
  logic [POS_W-1:0]  last_end_q, last_end_d;
  logic [POS_W-1:0]  cur_start_q, cur_start_d;
  logic [POS_W-1:0]  cur_end_q, cur_end_d;
  logic [AW-1:0]     idx_q, idx_d;
  logic [POS_W-1:0]  prefix_q, prefix_d;
  logic [POS_W-1:0]  contrib_q, contrib_d;
  logic [POS_W-1:0]  rd_start_q, rd_end_q;

  // result register
  rsp_status_e       res_status_q, res_status_d;
  base_e             res_base_q, res_base_d;
  logic              res_illegal_q, res_illegal_d;
  logic [POS_W-1:0]  res_spos_q, res_spos_d;
  logic [POS_W-1:0]  res_cpos_q, res_cpos_d;

  logic             tbl_full;
  logic             tbl_we;
  logic [AW-1:0]    tbl_waddr;
  logic             restart;
  base_dec_t        dec;
  logic [POS_W-1:0] emit_cnt;

  assign tbl_full  = !merge_q && (count_q == CW'(MAX_EXONS));
  assign tbl_we    = (cmd_i.act == DP_LD_UPD) && !tbl_full;
  assign tbl_waddr = merge_q ? AW'(count_q - CW'(1)) : AW'(count_q);
  assign dec       = decode_char(ch_q);
  assign emit_cnt  = emitted_q + POS_W'(1);

  always_comb begin
    sts_o.count_zero  = (count_q == '0);
    sts_o.surplus     = (emitted_q >= total_q);
    sts_o.is_dash     = (ch_q == CHAR_DASH);
    sts_o.started     = started_q;
    sts_o.at_end      = strand_q ? (cursor_pos_q == cur_start_q) : (cursor_pos_q == cur_end_q);
    sts_o.next_none   = strand_q ? (cursor_exon_q == '0)
                                 : ((CW'(cursor_exon_q) + CW'(1)) == count_q);
    sts_o.rd_nonempty = (rd_end_q >= rd_start_q);
    sts_o.idx_last    = ((CW'(idx_q) + CW'(1)) == count_q);
    sts_o.scan_bound  = strand_q ? (idx_q == '0) : sts_o.idx_last;
    sts_o.q_break     = (rd_start_q > qpos_q);
  end

  always_comb begin
    count_d       = count_q;
    total_d       = total_q;
    emitted_d     = emitted_q;
    cursor_exon_d = cursor_exon_q;
    cursor_pos_d  = cursor_pos_q;
    started_d     = started_q;
    strand_d      = strand_q;
    first_d       = first_q;
    last_d        = last_q;
    ch_d          = ch_q;
    qpos_d        = qpos_q;
    fix_last_d    = fix_last_q;
    merge_d       = merge_q;
    new_len_d     = new_len_q;
    old_len_d     = old_len_q;
    last_start_d  = last_start_q;
    last_end_d    = last_end_q;
    cur_start_d   = cur_start_q;
    cur_end_d     = cur_end_q;
    idx_d         = idx_q;
    prefix_d      = prefix_q;
    contrib_d     = contrib_q;
    res_status_d  = res_status_q;
    res_base_d    = res_base_q;
    res_illegal_d = res_illegal_q;
    res_spos_d    = res_spos_q;
    res_cpos_d    = res_cpos_q;
    restart       = 1'b0;

    if (is_result_act(cmd_i.act)) begin
      res_status_d  = cmd_i.code;
      res_base_d    = BASE_A;
      res_illegal_d = 1'b0;
      res_spos_d    = '0;
      res_cpos_d    = '0;
    end

    case (cmd_i.act)
      DP_CAPTURE: begin
        first_d = exon_first_i;
        last_d  = exon_last_i;
        ch_d    = char_in_i;
        qpos_d  = query_position_i;
      end
      DP_LD_FIX: begin
        // reversed pair turns into an empty exon
        fix_last_d = (last_q < first_q) ? (first_q - POS_W'(1)) : last_q;
        merge_d    = (count_q != '0) && (first_q <= last_end_q);
      end
      DP_LD_LEN: begin
        new_len_d = exon_len(merge_q ? last_start_q : first_q, fix_last_q);
        old_len_d = merge_q ? exon_len(last_start_q, last_end_q) : '0;
      end
      DP_LD_UPD: begin
        if (tbl_full) begin
          res_status_d = ST_FULL;
        end else begin
          // total kept incrementally: swap old length of the last entry for new
          total_d    = total_q + new_len_q - old_len_q;
          last_end_d = fix_last_q;
          if (!merge_q) begin
            count_d      = count_q + CW'(1);
            last_start_d = first_q;
          end
          restart      = 1'b1;
          res_status_d = ST_DONE;
        end
      end
      DP_CLEAR: begin
        count_d      = '0;
        total_d      = '0;
        restart      = 1'b1;
        res_status_d = ST_DONE;
      end
      DP_Q_INIT: begin
        idx_d    = '0;
        prefix_d = '0;
      end
      DP_Q_CHK: begin
        contrib_d = (rd_end_q >= qpos_q) ? (qpos_q - rd_start_q)
                                         : exon_len(rd_start_q, rd_end_q);
      end
      DP_Q_ADD: begin
        prefix_d = prefix_q + contrib_q;
        idx_d    = idx_q + AW'(1);
      end
      DP_Q_FIN: begin
        res_status_d = ST_QUERY;
        res_spos_d   = strand_q ? (total_q - prefix_q) : (prefix_q + POS_W'(1));
        res_cpos_d   = qpos_q;
      end
      DP_EMIT: begin
        res_status_d  = ST_BASE;
        res_base_d    = dec.base;
        res_illegal_d = dec.illegal;
        res_spos_d    = emit_cnt;
        res_cpos_d    = cursor_pos_q;
        emitted_d     = emit_cnt;
        if (!sts_o.at_end) begin
          cursor_pos_d = strand_q ? (cursor_pos_q - POS_W'(1)) : (cursor_pos_q + POS_W'(1));
        end
      end
      DP_SCAN_HEAD: begin
        idx_d = strand_q ? AW'(count_q - CW'(1)) : '0;
      end
      DP_SCAN_NEXT: begin
        idx_d = strand_q ? (cursor_exon_q - AW'(1)) : (cursor_exon_q + AW'(1));
      end
      DP_SCAN_STEP: begin
        idx_d = strand_q ? (idx_q - AW'(1)) : (idx_q + AW'(1));
      end
      DP_SCAN_FOUND: begin
        cursor_exon_d = idx_q;
        cursor_pos_d  = strand_q ? rd_end_q : rd_start_q;
        cur_start_d   = rd_start_q;
        cur_end_d     = rd_end_q;
        started_d     = 1'b1;
      end
      DP_EXHAUST: begin
        emitted_d = total_q;
      end
      DP_EXH_DROP: begin
        emitted_d    = total_q;
        res_status_d = ST_DROP;
      end
      default: ;
    endcase

    if (strand_minus_we_i) begin
      strand_d = strand_minus_i;
      restart  = 1'b1;
    end

    if (restart) begin
      emitted_d     = '0;
      started_d     = 1'b0;
      cursor_exon_d = '0;
      cursor_pos_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q       <= '0;
      total_q       <= '0;
      emitted_q     <= '0;
      cursor_exon_q <= '0;
      cursor_pos_q  <= '0;
      started_q     <= 1'b0;
      strand_q      <= 1'b0;
    end else begin
      count_q       <= count_d;
      total_q       <= total_d;
      emitted_q     <= emitted_d;
      cursor_exon_q <= cursor_exon_d;
      cursor_pos_q  <= cursor_pos_d;
      started_q     <= started_d;
      strand_q      <= strand_d;
    end
  end

  always_ff @(posedge clk_i) begin
    first_q       <= first_d;
    last_q        <= last_d;
    ch_q          <= ch_d;
    qpos_q        <= qpos_d;
    fix_last_q    <= fix_last_d;
    merge_q       <= merge_d;
    new_len_q     <= new_len_d;
    old_len_q     <= old_len_d;
    last_start_q  <= last_start_d;
    last_end_q    <= last_end_d;
    cur_start_q   <= cur_start_d;
    cur_end_q     <= cur_end_d;
    idx_q         <= idx_d;
    prefix_q      <= prefix_d;
    contrib_q     <= contrib_d;
    res_status_q  <= res_status_d;
    res_base_q    <= res_base_d;
    res_illegal_q <= res_illegal_d;
    res_spos_q    <= res_spos_d;
    res_cpos_q    <= res_cpos_d;
  end

  // one write port, one registered read port at the scan index
  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      start_mem[tbl_waddr] <= merge_q ? last_start_q : first_q;
      end_mem[tbl_waddr]   <= fix_last_q;
    end
    rd_start_q <= start_mem[idx_q];
    rd_end_q   <= end_mem[idx_q];
  end

  assign status_o         = res_status_q;
  assign base_code_o      = res_base_q;
  assign illegal_char_o   = res_illegal_q;
  assign seq_position_o   = res_spos_q;
  assign chrom_position_o = res_cpos_q;

endmodule

@@ design/etcm_ctrl.sv @@
// ----------------------------------------------------------------------------
// etcm_ctrl
// Sequencer: accepts one command word at a time, steps the datapath through
// load, clear, query and character flows, and owns the result valid flag.
// ----------------------------------------------------------------------------
module etcm_ctrl import etcm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       req_valid_i,
  input  logic [1:0] req_opcode_i,
  output logic       req_ready_o,
  output logic       rsp_valid_o,
  input  logic       rsp_ready_i,
  input  etcm_sts_t  sts_i,
  output etcm_cmd_t  cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE,
    S_LD_FIX,
    S_LD_LEN,
    S_LD_UPD,
    S_CLR,
    S_Q_INIT,
    S_Q_RD,
    S_Q_CHK,
    S_Q_ADD,
    S_Q_FIN,
    S_C_CHK,
    S_SC_HEAD,
    S_SC_RD,
    S_SC_CHK,
    S_EMIT,
    S_NX_INIT,
    S_EXH_DROP
  } state_e;

  state_e state_q, state_d;
  logic   head_q, head_d;     // scan serves the first base of the stream
  logic   valid_q, valid_d;
  logic   out_free;

  assign out_free    = !valid_q || rsp_ready_i;
  assign req_ready_o = (state_q == S_IDLE);
  assign rsp_valid_o = valid_q;

  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    cmd_o.act  = DP_NOP;
    cmd_o.code = ST_DONE;

    case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          cmd_o.act = DP_CAPTURE;
          case (opcode_e'(req_opcode_i))
            OP_LOAD:  state_d = S_LD_FIX;
            OP_CHAR:  state_d = S_C_CHK;
            OP_QUERY: state_d = S_Q_INIT;
            OP_CLEAR: state_d = S_CLR;
            default:  state_d = S_IDLE;
          endcase
        end
      end
      S_LD_FIX: begin
        cmd_o.act = DP_LD_FIX;
        state_d   = S_LD_LEN;
      end
      S_LD_LEN: begin
        cmd_o.act = DP_LD_LEN;
        state_d   = S_LD_UPD;
      end
      S_LD_UPD: begin
        if (out_free) begin
          cmd_o.act = DP_LD_UPD;
          state_d   = S_IDLE;
        end
      end
      S_CLR: begin
        if (out_free) begin
          cmd_o.act = DP_CLEAR;
          state_d   = S_IDLE;
        end
      end
      S_Q_INIT: begin
        cmd_o.act = DP_Q_INIT;
        state_d   = sts_i.count_zero ? S_Q_FIN : S_Q_RD;
      end
      S_Q_RD: begin
        state_d = S_Q_CHK;
      end
      S_Q_CHK: begin
        if (sts_i.q_break) begin
          state_d = S_Q_FIN;
        end else begin
          cmd_o.act = DP_Q_CHK;
          state_d   = S_Q_ADD;
        end
      end
      S_Q_ADD: begin
        cmd_o.act = DP_Q_ADD;
        state_d   = sts_i.idx_last ? S_Q_FIN : S_Q_RD;
      end
      S_Q_FIN: begin
        if (out_free) begin
          cmd_o.act = DP_Q_FIN;
          state_d   = S_IDLE;
        end
      end
      S_C_CHK: begin
        if (sts_i.surplus) begin
          if (out_free) begin
            cmd_o.act  = DP_RES;
            cmd_o.code = ST_DROP;
            state_d    = S_IDLE;
          end
        end else if (sts_i.is_dash) begin
          if (out_free) begin
            cmd_o.act  = DP_RES;
            cmd_o.code = ST_GAP;
            state_d    = S_IDLE;
          end
        end else if (!sts_i.started) begin
          state_d = S_SC_HEAD;
        end else if (out_free) begin
          cmd_o.act = DP_EMIT;
          state_d   = sts_i.at_end ? S_NX_INIT : S_IDLE;
        end
      end
      S_SC_HEAD: begin
        if (sts_i.count_zero) begin
          state_d = S_EXH_DROP;
        end else begin
          cmd_o.act = DP_SCAN_HEAD;
          head_d    = 1'b1;
          state_d   = S_SC_RD;
        end
      end
      S_NX_INIT: begin
        if (sts_i.next_none) begin
          cmd_o.act = DP_EXHAUST;
          state_d   = S_IDLE;
        end else begin
          cmd_o.act = DP_SCAN_NEXT;
          head_d    = 1'b0;
          state_d   = S_SC_RD;
        end
      end
      S_SC_RD: begin
        state_d = S_SC_CHK;
      end
      S_SC_CHK: begin
        if (sts_i.rd_nonempty) begin
          cmd_o.act = DP_SCAN_FOUND;
          state_d   = head_q ? S_EMIT : S_IDLE;
        end else if (sts_i.scan_bound) begin
          if (head_q) begin
            state_d = S_EXH_DROP;
          end else begin
            cmd_o.act = DP_EXHAUST;
            state_d   = S_IDLE;
          end
        end else begin
          cmd_o.act = DP_SCAN_STEP;
          state_d   = S_SC_RD;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          cmd_o.act = DP_EMIT;
          state_d   = sts_i.at_end ? S_NX_INIT : S_IDLE;
        end
      end
      S_EXH_DROP: begin
        if (out_free) begin
          cmd_o.act = DP_EXH_DROP;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (is_result_act(cmd_o.act)) begin
      valid_d = 1'b1;
    end else if (rsp_ready_i) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      valid_q <= valid_d;
    end
  end

endmodule

@@ design/exon_transcript_coordinate_mapper.sv @@
// Flow: one word at a time. Crossing an exon edge adds a scan of the table entries, and so
// does the first base of a stream. A query steps through the exons at or below the
// position, and an exon that starts above it ends the walk.
// Reset (rst_ni, async, active low) empties the table, zeroes the total length and the
// stream cursor and selects the plus strand; table memory contents are not cleared.
// ----------------------------------------------------------------------------
// exon_transcript_coordinate_mapper
// Exon table with transcript/chromosome coordinate mapping of streamed bases.
// ----------------------------------------------------------------------------
module exon_transcript_coordinate_mapper import etcm_pkg::*; #(
  parameter int MAX_EXONS = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  etcm_req_if.sink   req_i,
  etcm_rsp_if.source rsp_o,
  input  logic       strand_minus_we_i,
  input  logic       strand_minus_i
);

  etcm_cmd_t cmd;
  etcm_sts_t sts;

  etcm_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (req_i.valid),
    .req_opcode_i (req_i.opcode),
    .req_ready_o  (req_i.ready),
    .rsp_valid_o  (rsp_o.valid),
    .rsp_ready_i  (rsp_o.ready),
    .sts_i        (sts),
    .cmd_o        (cmd)
  );

  etcm_datapath #(
    .MAX_EXONS (MAX_EXONS)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .exon_first_i      (req_i.exon_first),
    .exon_last_i       (req_i.exon_last),
    .char_in_i         (req_i.char_in),
    .query_position_i  (req_i.query_position),
    .strand_minus_we_i (strand_minus_we_i),
    .strand_minus_i    (strand_minus_i),
    .status_o          (rsp_o.status),
    .base_code_o       (rsp_o.base_code),
    .illegal_char_o    (rsp_o.illegal_char),
    .seq_position_o    (rsp_o.seq_position),
    .chrom_position_o  (rsp_o.chrom_position)
  );

endmodule

@@ design/etcm_checker.sv @@
// ----------------------------------------------------------------------------
// etcm_checker
// Port-level checks of the coordinate mapper, bound to the top level.
// ----------------------------------------------------------------------------
module etcm_checker import etcm_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             req_valid_i,
  input logic             req_ready_i,
  input logic             rsp_valid_i,
  input logic             rsp_ready_i,
  input logic [2:0]       status_i,
  input logic [2:0]       base_code_i,
  input logic             illegal_char_i,
  input logic [POS_W-1:0] seq_position_i,
  input logic [POS_W-1:0] chrom_position_i
);

  // one word in flight: ready drops right after an accept
  a_ready_drops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request accepted while a word is in flight");

  a_base_only_on_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (status_i != ST_BASE) |-> (base_code_i == '0) && !illegal_char_i)
    else $error("base fields set on a non-base result");

  a_no_pos_on_plain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && ((status_i == ST_DONE) || (status_i == ST_GAP) ||
                    (status_i == ST_DROP) || (status_i == ST_FULL))
    |-> (seq_position_i == '0) && (chrom_position_i == '0))
    else $error("positions set on a result that carries none");

  a_illegal_masked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && illegal_char_i |-> (base_code_i == BASE_MASK))
    else $error("illegal character not masked");

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(status_i) &&
                                    $stable(seq_position_i))
    else $error("stalled result changed");

endmodule

bind exon_transcript_coordinate_mapper etcm_checker u_etcm_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .req_valid_i      (req_i.valid),
  .req_ready_i      (req_i.ready),
  .rsp_valid_i      (rsp_o.valid),
  .rsp_ready_i      (rsp_o.ready),
  .status_i         (rsp_o.status),
  .base_code_i      (rsp_o.base_code),
  .illegal_char_i   (rsp_o.illegal_char),
  .seq_position_i   (rsp_o.seq_position),
  .chrom_position_i (rsp_o.chrom_position)
);

@@ sim/exon_transcript_coordinate_mapper_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// exon_transcript_coordinate_mapper_tb
// Drives exon loads, clears, sequence characters and position queries
// through the request channel with random idling. Each accepted word runs
// through a local model of the exon table and the base walk. Every response
// word is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module exon_transcript_coordinate_mapper_tb;
  import etcm_pkg::*;

  localparam int          MAX_EXONS   = 64;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam logic [12*CHAR_W-1:0] BASE_CHARS = "ACGTUXacgtux";

  typedef struct packed {
    rsp_status_e      status;
    base_e            base;
    logic             illegal;
    logic [POS_W-1:0] seq_pos;
    logic [POS_W-1:0] chrom_pos;
  } map_rsp_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic strand_we;
  logic strand_val;

  etcm_req_if req ();
  etcm_rsp_if rsp ();

  exon_transcript_coordinate_mapper #(
    .MAX_EXONS (MAX_EXONS)
  ) u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .req_i             (req),
    .rsp_o             (rsp),
    .strand_minus_we_i (strand_we),
    .strand_minus_i    (strand_val)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Local copy of the exon table and stream cursor
  logic [POS_W-1:0] exon_lo [MAX_EXONS];
  logic [POS_W-1:0] exon_hi [MAX_EXONS];
  int               n_exons = 0;
  logic [POS_W-1:0] tx_len = '0;
  logic [POS_W-1:0] emitted = '0;
  int               walk_idx = 0;
  logic [POS_W-1:0] walk_pos = '0;
  bit               walk_on = 1'b0;
  bit               minus_strand = 1'b0;

  map_rsp_t    due_rsp [$];
  int          err_cnt = 0;
  int          words_sent = 0;
  int          words_checked = 0;
  int          status_seen [6];
  bit          idle_on = 1'b1;
  int unsigned rx_hold_cycles = 0;
  int unsigned cycle_cnt = 0;

  function automatic logic [POS_W-1:0] span(int i);
    return (exon_hi[i] >= exon_lo[i]) ? exon_hi[i] - exon_lo[i] + 1 : '0;
  endfunction

  function automatic void stream_restart();
    emitted  = '0;
    walk_on  = 1'b0;
    walk_idx = 0;
    walk_pos = '0;
  endfunction

  // next non-empty exon from i in the walk direction, n_exons if none
  function automatic int next_live(int i, bit down);
    int j;
    j = i;
    while (j >= 0 && j < n_exons) begin
      if (exon_hi[j] >= exon_lo[j]) return j;
      j = down ? j - 1 : j + 1;
    end
    return n_exons;
  endfunction

  function automatic void map_word(opcode_e op, logic [POS_W-1:0] first,
                                   logic [POS_W-1:0] last, logic [CHAR_W-1:0] ch,
                                   logic [POS_W-1:0] q);
    map_rsp_t         r;
    logic [POS_W-1:0] acc;
    int               k;
    int               nx;
    r.status    = ST_DONE;
    r.base      = BASE_A;
    r.illegal   = 1'b0;
    r.seq_pos   = '0;
    r.chrom_pos = '0;
    case (op)
      OP_LOAD: begin
        if (last < first) last = first - 1;
        if (n_exons > 0 && first <= exon_hi[n_exons-1]) begin
          exon_hi[n_exons-1] = last;
        end else if (n_exons >= MAX_EXONS) begin
          r.status = ST_FULL;
        end else begin
          exon_lo[n_exons] = first;
          exon_hi[n_exons] = last;
          n_exons++;
        end
        if (r.status == ST_DONE) begin
          tx_len = '0;
          for (int i = 0; i < n_exons; i++) tx_len += span(i);
          stream_restart();
        end
      end
      OP_CLEAR: begin
        n_exons = 0;
        tx_len  = '0;
        stream_restart();
      end
      OP_QUERY: begin
        acc = '0;
        for (int i = 0; i < n_exons; i++) begin
          if (exon_lo[i] > q) break;
          if (exon_hi[i] >= q) acc += q - exon_lo[i];
          else acc += span(i);
        end
        r.status    = ST_QUERY;
        r.seq_pos   = minus_strand ? tx_len - acc : acc + 1;
        r.chrom_pos = q;
      end
      default: begin
        if (emitted >= tx_len) begin
          r.status = ST_DROP;
        end else if (ch == CHAR_DASH) begin
          r.status = ST_GAP;
        end else begin
          if (!walk_on) begin
            k = minus_strand ? next_live(n_exons - 1, 1'b1) : next_live(0, 1'b0);
            if (k >= n_exons) begin
              emitted  = tx_len;
              r.status = ST_DROP;
            end else begin
              walk_idx = k;
              walk_pos = minus_strand ? exon_hi[k] : exon_lo[k];
              walk_on  = 1'b1;
            end
          end
          if (r.status != ST_DROP) begin
            k = walk_idx;
            case (ch)
              CHAR_A_UP, CHAR_A_LO: r.base = BASE_A;
              CHAR_C_UP, CHAR_C_LO: r.base = BASE_C;
              CHAR_G_UP, CHAR_G_LO: r.base = BASE_G;
              CHAR_T_UP, CHAR_T_LO, CHAR_U_UP, CHAR_U_LO: r.base = BASE_U;
              CHAR_X_UP, CHAR_X_LO: r.base = BASE_MASK;
              default: begin
                r.base    = BASE_MASK;
                r.illegal = 1'b1;
              end
            endcase
            emitted++;
            r.status    = ST_BASE;
            r.seq_pos   = emitted;
            r.chrom_pos = walk_pos;
            if (!minus_strand && walk_pos != exon_hi[k]) begin
              walk_pos++;
            end else if (minus_strand && walk_pos != exon_lo[k]) begin
              walk_pos--;
            end else begin
              nx = minus_strand ? next_live(k - 1, 1'b1) : next_live(k + 1, 1'b0);
              if (nx >= n_exons) begin
                emitted = tx_len;
              end else begin
                walk_idx = nx;
                walk_pos = minus_strand ? exon_hi[nx] : exon_lo[nx];
              end
            end
          end
        end
      end
    endcase
    due_rsp = {due_rsp, r};
  endfunction

  // a: first / char / query position by opcode, b: last; unused fields get noise
  task automatic send_word(opcode_e op, logic [POS_W-1:0] a, logic [POS_W-1:0] b);
    logic [POS_W-1:0]  first;
    logic [POS_W-1:0]  last;
    logic [POS_W-1:0]  q;
    logic [CHAR_W-1:0] ch;
    int                gap;
    first = $urandom;
    last  = $urandom;
    q     = $urandom;
    ch    = CHAR_W'($urandom);
    case (op)
      OP_LOAD: begin
        first = a;
        last  = b;
      end
      OP_CHAR:  ch = a[CHAR_W-1:0];
      OP_QUERY: q = a;
      default: ;
    endcase
    gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 11) : 0;
    repeat (gap) begin
      @(negedge clk_i);
      req.valid <= 1'b0;
    end
    @(negedge clk_i);
    req.valid          <= 1'b1;
    req.opcode         <= op;
    req.exon_first     <= first;
    req.exon_last      <= last;
    req.char_in        <= ch;
    req.query_position <= q;
    do @(posedge clk_i); while (!req.ready);
    map_word(op, first, last, ch, q);
    words_sent++;
  endtask

  task automatic drain();
    @(negedge clk_i);
    req.valid <= 1'b0;
    while (due_rsp.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_strand(bit v);
    drain();
    // an exon scan may still run after the last result went out
    do @(posedge clk_i); while (!req.ready);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    strand_we  <= 1'b1;
    strand_val <= v;
    @(negedge clk_i);
    strand_we <= 1'b0;
    minus_strand = v;
    stream_restart();
  endtask

  function automatic logic [CHAR_W-1:0] pick_char();
    int r;
    r = $urandom_range(0, 19);
    if (r < 14) return BASE_CHARS[CHAR_W*$urandom_range(0, 11) +: CHAR_W];
    if (r < 17) return CHAR_DASH;
    return CHAR_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [POS_W-1:0] pick_query();
    int idx;
    if (n_exons == 0) return $urandom;
    idx = $urandom_range(0, n_exons - 1);
    case ($urandom_range(0, 5))
      0: return exon_lo[idx] - 1;
      1: return exon_lo[idx];
      2: return exon_hi[idx];
      3: return exon_hi[idx] + 1;
      4: return $urandom;
      default: return exon_lo[idx] + $urandom_range(0, 8);
    endcase
  endfunction

  // appends one pair after pos: mostly disjoint, some reversed, some overlapping
  task automatic add_exon(inout logic [POS_W-1:0] pos);
    logic [POS_W-1:0] first;
    logic [POS_W-1:0] last;
    case ($urandom_range(0, 7))
      0: begin
        first = pos + $urandom_range(1, 20);
        last  = first - $urandom_range(1, 5);
        pos   = first - 1;
      end
      1: begin
        first = pos - $urandom_range(0, 2);
        last  = pos + $urandom_range(0, 6);
        pos   = last;
      end
      default: begin
        first = pos + $urandom_range(1, 20);
        last  = first + $urandom_range(0, 7);
        pos   = last;
      end
    endcase
    send_word(OP_LOAD, first, last);
  endtask

  task automatic stream_phase(bit strand, int max_chars);
    logic [POS_W-1:0] pos;
    int               n;
    set_strand(strand);
    send_word(OP_CLEAR, '0, '0);
    pos = ($urandom_range(0, 9) == 0) ? 32'hFFFF_F000 + $urandom_range(0, 255)
                                      : $urandom_range(0, 100000);
    repeat ($urandom_range(1, 6)) add_exon(pos);
    n = (tx_len > max_chars) ? max_chars : int'(tx_len) + $urandom_range(0, 4);
    repeat (n) begin
      case ($urandom_range(0, 29))
        0, 1, 2: send_word(OP_QUERY, pick_query(), '0);
        3:       add_exon(pos);
        default: send_word(OP_CHAR, POS_W'(pick_char()), '0);
      endcase
    end
  endtask

  task automatic test_directed();
    set_strand(1'b0);
    send_word(OP_CHAR, POS_W'(CHAR_A_UP), '0);       // empty table: dropped
    send_word(OP_QUERY, '0, '0);
    send_word(OP_LOAD, 32'd100, 32'd101);
    send_word(OP_LOAD, 32'd101, 32'd103);    // overlap, merged
    send_word(OP_LOAD, 32'd200, 32'd150);    // reversed, empty exon
    send_word(OP_LOAD, 32'd300, 32'd301);
    send_word(OP_QUERY, 32'd102, '0);
    send_word(OP_QUERY, 32'hFFFF_FFFF, '0);
    send_word(OP_CHAR, POS_W'(CHAR_A_LO), '0);
    send_word(OP_CHAR, POS_W'(CHAR_C_UP), '0);
    send_word(OP_CHAR, POS_W'(CHAR_DASH), '0);
    send_word(OP_CHAR, POS_W'(CHAR_T_LO), '0);
    send_word(OP_CHAR, POS_W'(CHAR_U_UP), '0);       // end of first exon, skip the empty one
    send_word(OP_CHAR, POS_W'(CHAR_X_LO), '0);
    send_word(OP_CHAR, 32'h0000_0000, '0);           // illegal, last base: walk runs out
    send_word(OP_CHAR, 32'h0000_00FF, '0);           // surplus
    send_word(OP_CHAR, POS_W'(CHAR_DASH), '0);       // surplus dash
    send_word(OP_CLEAR, '0, '0);
    send_word(OP_CHAR, POS_W'(CHAR_G_LO), '0);
    send_word(OP_LOAD, '0, 32'hFFFF_FFFF);   // length wraps to zero
    send_word(OP_CHAR, POS_W'(CHAR_G_UP), '0);
    send_word(OP_QUERY, 32'h8000_0000, '0);
  endtask

  task automatic test_table_full();
    logic [POS_W-1:0] s;
    set_strand(1'b1);
    send_word(OP_CLEAR, '0, '0);
    for (int i = 0; i < MAX_EXONS; i++) begin
      s = i * 16 + 7;
      send_word(OP_LOAD, s, (i % 8 == 5) ? s - 3 : s + (i % 3));
    end
    send_word(OP_LOAD, 32'd2000, 32'd2001);  // no room
    send_word(OP_LOAD, 32'd5000, 32'd4000);  // no room, reversed
    send_word(OP_LOAD, s, s + 5);            // merge still allowed
    repeat (12) send_word(OP_CHAR, POS_W'(pick_char()), '0);
    send_word(OP_QUERY, 32'd500, '0);
    send_word(OP_QUERY, 32'hFFFF_FFFF, '0);
    send_word(OP_QUERY, '0, '0);
  endtask

  task automatic test_stream_mix(int target);
    int phase;
    phase = 0;
    while (words_sent < target) begin
      idle_on = ($urandom_range(0, 3) != 0);
      stream_phase((phase < 2) ? phase[0] : 1'($urandom_range(0, 1)), 60);
      phase++;
    end
    idle_on = 1'b1;
  endtask

  task automatic test_backpressure();
    logic [POS_W-1:0] pos;
    drain();
    @(posedge clk_i);
    rx_hold_cycles = 300;
    send_word(OP_CLEAR, '0, '0);
    pos = $urandom_range(0, 1000);
    repeat (3) add_exon(pos);
    repeat (16) send_word(OP_CHAR, POS_W'(pick_char()), '0);
  endtask

  task automatic test_random_words(int n);
    repeat (n) send_word(opcode_e'($urandom_range(0, 3)), $urandom, $urandom);
  endtask

  task automatic test_back_to_back();
    idle_on = 1'b0;
    stream_phase(1'b1, 25);
    stream_phase(1'b0, 25);
  endtask

  // response side: random stall bursts, plus long hold-offs on request
  initial begin : rx_side
    int unsigned stall_left;
    stall_left = 0;
    rsp.ready  = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_hold_cycles != 0) begin
        rsp.ready <= 1'b0;
        rx_hold_cycles--;
      end else if (stall_left != 0) begin
        rsp.ready <= 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        rsp.ready <= 1'b0;
        stall_left = $urandom_range(0, 10);
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  function automatic void flag_err(string what, logic [POS_W-1:0] want, logic [POS_W-1:0] got);
    err_cnt++;
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
  endfunction

  always @(posedge clk_i) begin : rsp_check
    map_rsp_t e;
    if (rst_ni && rsp.valid && rsp.ready) begin
      if (rsp.status <= ST_FULL) status_seen[rsp.status]++;
      if (due_rsp.size() == 0) begin
        err_cnt++;
        $display("%0t: result word, expected none, actual status %0d seq %0h chrom %0h",
                 $time, rsp.status, rsp.seq_position, rsp.chrom_position);
      end else begin
        e = due_rsp.pop_front();
        words_checked++;
        if (rsp.status !== e.status) flag_err("status", e.status, rsp.status);
        if (rsp.base_code !== e.base) flag_err("base_code", e.base, rsp.base_code);
        if (rsp.illegal_char !== e.illegal) flag_err("illegal_char", e.illegal, rsp.illegal_char);
        if (rsp.seq_position !== e.seq_pos) flag_err("seq_position", e.seq_pos, rsp.seq_position);
        if (rsp.chrom_position !== e.chrom_pos)
          flag_err("chrom_position", e.chrom_pos, rsp.chrom_position);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt, due_rsp.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    foreach (status_seen[i]) status_seen[i] = 0;
    rst_ni             = 1'b0;
    strand_we          = 1'b0;
    strand_val         = 1'b0;
    req.valid          = 1'b0;
    req.opcode         = OP_CLEAR;
    req.exon_first     = '0;
    req.exon_last      = '0;
    req.char_in        = '0;
    req.query_position = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_table_full();
    test_stream_mix(450);
    test_backpressure();
    test_random_words(80);
    test_back_to_back();

    drain();
    repeat (20) @(posedge clk_i);
    $display("Run: %0d words sent, %0d results checked, both strands, full table reached.",
             words_sent, words_checked);
    $display("Results: %0d bases, %0d gaps, %0d dropped, %0d queries, %0d full, %0d done.",
             status_seen[ST_BASE], status_seen[ST_GAP], status_seen[ST_DROP],
             status_seen[ST_QUERY], status_seen[ST_FULL], status_seen[ST_DONE]);
    if (err_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/etcm_pkg.sv
design/etcm_req_if.sv
design/etcm_rsp_if.sv
design/etcm_datapath.sv
design/etcm_ctrl.sv
design/exon_transcript_coordinate_mapper.sv
design/etcm_checker.sv
sim/exon_transcript_coordinate_mapper_tb.sv
